### hw/rtl/assert_macros.svh
// Assertion macros for the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define ASSERT_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Concurrent assertion that is checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

### hw/rtl/dvr_pkg.sv
// Package with the types, constants and codes of the distinct value rank engine.
package dvr_pkg;

  localparam int VALUE_W     = 32;
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int MAX_COUNT   = 64;
  localparam int CAPACITY    = (MAX_COUNT > STORE_DEPTH) ? STORE_DEPTH :
                               ((MAX_COUNT < 1) ? 1 : MAX_COUNT);
  localparam int RANK_W      = 6;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [RANK_W-1:0]         rank_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_PIVOT_RD,
    S_PIVOT_LD,
    S_COUNT,
    S_EMIT_RANK,
    S_EMIT_ERR
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    scan_start;
    logic    scan_run;
    logic    pivot_rd;
    logic    pivot_ld;
    logic    store_wr;
    logic    clear_store;
    logic    idx_clear;
    logic    idx_inc;
    logic    emit;
    logic    emit_err;
    status_t emit_status;
  } dvr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dup_hit;
    logic scan_done;
    logic full;
    logic last_pivot;
    logic slot_free;
    logic item_final;
  } dvr_stat_t;

endpackage

### hw/rtl/dvr_if.sv
// Channel interfaces for the input values and the rank results.
interface dvr_in_if;
  logic               valid;
  logic               ready;
  dvr_pkg::value_t    value;
  logic               final_item;

  modport source (output valid, output value, output final_item, input ready);
  modport sink   (input valid, input value, input final_item, output ready);
endinterface

interface dvr_out_if;
  logic               valid;
  logic               ready;
  dvr_pkg::rank_t     rank;
  dvr_pkg::status_t   status;
  logic               last_result;

  modport source (output valid, output rank, output status, output last_result, input ready);
  modport sink   (input valid, input rank, input status, input last_result, output ready);
endinterface

### hw/rtl/dvr_datapath.sv
// Datapath: value store, scan counters, comparators, rank counter and output register.
`include "assert_macros.svh"

module dvr_datapath (
  input  logic               clk,
  input  logic               rst,
  input  dvr_pkg::value_t    in_value,
  input  logic               in_final,
  input  dvr_pkg::dvr_cmd_t  cmd,
  output dvr_pkg::dvr_stat_t stat,
  input  logic               out_ready,
  output logic               out_valid,
  output dvr_pkg::rank_t     out_rank,
  output dvr_pkg::status_t   out_status,
  output logic               out_last
);
  import dvr_pkg::*;

  value_t mem [STORE_DEPTH];
  value_t rdata;
  value_t item_value;
  value_t pivot;
  logic   item_final;
  cnt_t   stored_count;
  cnt_t   scan_idx;
  cnt_t   pivot_idx;
  cnt_t   pivot_idx_next;
  cnt_t   smaller;
  logic   cmp_vld;
  logic   rd_issue;
  logic   rd_en;
  addr_t  raddr;
  logic   full;
  logic   slot_free;

  assign rd_issue       = cmd.scan_run && (scan_idx < stored_count);
  assign rd_en          = rd_issue || cmd.pivot_rd;
  assign raddr          = cmd.pivot_rd ? pivot_idx[ADDR_W-1:0] : scan_idx[ADDR_W-1:0];
  assign full           = stored_count >= CNT_W'(CAPACITY);
  assign slot_free      = !out_valid || out_ready;
  assign pivot_idx_next = pivot_idx + CNT_W'(1);

  always_comb begin
    stat.dup_hit    = cmp_vld && (rdata == item_value);
    stat.scan_done  = (scan_idx == stored_count) && !cmp_vld;
    stat.full       = full;
    stat.last_pivot = pivot_idx_next == stored_count;
    stat.slot_free  = slot_free;
    stat.item_final = item_final;
  end

  // Value store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.store_wr) begin
      mem[stored_count[ADDR_W-1:0]] <= item_value;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_value <= in_value;
      item_final <= in_final;
    end
    if (cmd.pivot_ld) begin
      pivot <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      scan_idx     <= '0;
      pivot_idx    <= '0;
      smaller      <= '0;
      cmp_vld      <= 1'b0;
    end else begin
      if (cmd.clear_store) begin
        stored_count <= '0;
      end else if (cmd.store_wr) begin
        stored_count <= stored_count + CNT_W'(1);
      end

      if (cmd.idx_clear) begin
        pivot_idx <= '0;
      end else if (cmd.idx_inc) begin
        pivot_idx <= pivot_idx_next;
      end

      if (cmd.scan_start) begin
        scan_idx <= '0;
        smaller  <= '0;
        cmp_vld  <= 1'b0;
      end else if (cmd.scan_run) begin
        if (rd_issue) begin
          scan_idx <= scan_idx + CNT_W'(1);
        end
        if (cmp_vld && (rdata < pivot)) begin
          smaller <= smaller + CNT_W'(1);
        end
        cmp_vld <= rd_issue;
      end else begin
        cmp_vld <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_rank   <= cmd.emit_err ? '0 : smaller[RANK_W-1:0];
      out_status <= cmd.emit_status;
      out_last   <= cmd.emit_err || stat.last_pivot;
    end
  end

  `ASSERT_RST(a_count_in_range, clk, rst, stored_count <= CNT_W'(CAPACITY))
  `ASSERT_RST(a_no_write_when_full, clk, rst, cmd.store_wr |-> !full)
  `ASSERT_RST(a_emit_into_free_slot, clk, rst, cmd.emit |-> slot_free)
  `ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !out_valid && stored_count == '0)

endmodule

### hw/rtl/dvr_ctrl.sv
// Controller state machine: sequences load, duplicate scan, ranking and result output.
module dvr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_final,
  output logic               in_ready,
  input  dvr_pkg::dvr_stat_t stat,
  output dvr_pkg::dvr_cmd_t  cmd
);
  import dvr_pkg::*;

  state_t  state;
  state_t  state_next;
  logic    discarding;
  logic    discarding_next;
  status_t err_code;
  status_t err_code_next;
  logic    accept;

  assign accept = in_valid && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      discarding <= 1'b0;
      err_code   <= ST_OK;
    end else begin
      state      <= state_next;
      discarding <= discarding_next;
      err_code   <= err_code_next;
    end
  end

  // Next state.
  always_comb begin
    state_next      = state;
    discarding_next = discarding;
    err_code_next   = err_code;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (discarding) begin
            discarding_next = !in_final;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat.dup_hit) begin
          err_code_next = ST_DUP;
          state_next    = S_EMIT_ERR;
        end else if (stat.scan_done) begin
          if (stat.full) begin
            err_code_next = ST_FULL;
            state_next    = S_EMIT_ERR;
          end else begin
            state_next = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        state_next = stat.item_final ? S_PIVOT_RD : S_IDLE;
      end
      S_PIVOT_RD: begin
        state_next = S_PIVOT_LD;
      end
      S_PIVOT_LD: begin
        state_next = S_COUNT;
      end
      S_COUNT: begin
        if (stat.scan_done) begin
          state_next = S_EMIT_RANK;
        end
      end
      S_EMIT_RANK: begin
        if (stat.slot_free) begin
          state_next = stat.last_pivot ? S_IDLE : S_PIVOT_RD;
        end
      end
      S_EMIT_ERR: begin
        if (stat.slot_free) begin
          discarding_next = !stat.item_final;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd             = '0;
    cmd.emit_status = ST_OK;
    in_ready        = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.capture    = accept && !discarding;
        cmd.scan_start = accept && !discarding;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
      end
      S_WRITE: begin
        cmd.store_wr  = 1'b1;
        cmd.idx_clear = 1'b1;
      end
      S_PIVOT_RD: begin
        cmd.pivot_rd = 1'b1;
      end
      S_PIVOT_LD: begin
        cmd.pivot_ld   = 1'b1;
        cmd.scan_start = 1'b1;
      end
      S_COUNT: begin
        cmd.scan_run = 1'b1;
      end
      S_EMIT_RANK: begin
        if (stat.slot_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_OK;
          cmd.idx_inc     = 1'b1;
          cmd.clear_store = stat.last_pivot;
        end
      end
      S_EMIT_ERR: begin
        if (stat.slot_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_err    = 1'b1;
          cmd.emit_status = err_code;
          cmd.clear_store = 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### hw/rtl/distinct_value_rank_engine_unit.sv
// Top level of the distinct value rank engine: controller plus datapath.
//
//   Channel   Direction  Payload                          Handshake
//   items     in         value[31:0] signed, final_item   valid / ready
//   results   out        rank[5:0], status[1:0], last     valid / ready
//
// A value that is not marked final is scanned against the values already held
// and then written to the store before the next value is taken. The duplicate
// scan reads the store once per cycle through its single registered read port.
// Once a final value is stored, one result is produced for each value held:
// one read fetches the value being ranked and a full pass over the store
// counts the smaller values. An error result is emitted after the duplicate
// scan. While the block is discarding the rest of a rejected set, it takes one
// transaction per cycle and gives no result.
// Synchronous reset empties the store and clears the discard flag; no
// clearing pass is needed because only written entries are ever read.
// New items are taken only in the idle state; a finished result waits in the
// output register, and only the next result is held back by a stalled sink.
module distinct_value_rank_engine_unit (
  input  logic      clk,
  input  logic      rst,
  dvr_in_if.sink    items,
  dvr_out_if.source results
);
  import dvr_pkg::*;

  dvr_cmd_t  cmd;
  dvr_stat_t stat;

  // The controller owns the input handshake and sequences every step of
  // the scan and ranking passes.
  dvr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_final (items.final_item),
    .in_ready (items.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the store, the counters and the output register that
  // drives the result channel.
  dvr_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_value   (items.value),
    .in_final   (items.final_item),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (results.ready),
    .out_valid  (results.valid),
    .out_rank   (results.rank),
    .out_status (results.status),
    .out_last   (results.last_result)
  );

endmodule
